@@ rtl/core/sha256_pkg.sv @@
// SHA-256 hasher package: round constants, initial hash values, shared types.
// No dependencies; used by every module under rtl/core.
package sha256_pkg;

    // Item passed from the front end to the compression back end
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       last_byte;
    } sha_item_t;

    localparam int QueueDepth = 4;
    localparam int QueueAw    = 2;

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

@@ rtl/core/sha256_front.sv @@
// SHA-256 front end: accepts items, drops idle ones, queues the rest.
// Depends on sha256_pkg.
module sha256_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            data_byte,
    input  logic                  has_data,
    input  logic                  last_byte,
    input  logic                  valid,
    output logic                  stall,
    output sha256_pkg::sha_item_t q_item,
    output logic                  q_valid,
    input  logic                  q_pop
);
    import sha256_pkg::*;

    sha_item_t          mem_reg [QueueDepth];
    logic [QueueAw-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueueAw-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueueAw:0]   count_reg, count_next;
    logic               push;
    logic               do_pop;

    // Full queue stalls the input; idle items are accepted and dropped
    assign stall   = (count_reg == QueueAw'(0) + (QueueAw+1)'(QueueDepth));
    assign push    = valid && !stall && (has_data || last_byte);
    assign q_valid = (count_reg != '0);
    assign do_pop  = q_pop && q_valid;
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QueueAw'(push);
        rd_ptr_next = rd_ptr_reg + QueueAw'(do_pop);
        count_next  = count_reg + (QueueAw+1)'(push) - (QueueAw+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{data_byte: data_byte, has_data: has_data,
                                     last_byte: last_byte};
        end
    end
endmodule

@@ rtl/core/sha256_back.sv @@
// SHA-256 back end: block packing, padding, 64-round compression, digest out.
// Depends on sha256_pkg.
module sha256_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha256_pkg::sha_item_t q_item,
    input  logic                  q_valid,
    output logic                  q_pop,
    output logic [31:0]           digest_word,
    output logic [2:0]            word_index,
    output logic                  last_word,
    output logic                  out_valid,
    input  logic                  out_stall
);
    import sha256_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LEN   = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_ADD   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] hash_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  round_reg;
    logic [2:0]  emit_reg;
    logic        final_reg;    // compression ends the message
    logic        pad80_reg;    // 0x80 already placed
    logic        len_done_reg; // length words written into the block

    logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;
    logic [3:0]  widx;
    logic [4:0]  shamt;
    logic [31:0] byte_word;
    logic [7:0]  put_val;
    logic        put_en;

    // Message schedule and round logic: w_reg holds the 16-word window
    always_comb
    begin
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + round_const(round_reg) + w_reg[0];
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    // Byte insertion
    always_comb
    begin
        widx      = fill_reg[5:2];
        shamt     = {~fill_reg[1:0], 3'b000};
        put_en    = 1'b0;
        put_val   = 8'h00;
        q_pop     = 1'b0;
        if (state_reg == ST_IDLE && q_valid)
        begin
            q_pop   = 1'b1;
            put_en  = q_item.has_data;
            put_val = q_item.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            put_en  = 1'b1;
            put_val = pad80_reg ? 8'h00 : 8'h80;
        end
        byte_word = (fill_reg[1:0] == 2'd0) ? 32'h0 : w_reg[widx];
        byte_word = byte_word | (32'(put_val) << shamt);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.has_data && fill_reg == 6'd63)
                        state_next = ST_ROUND;
                    else if (q_item.last_byte)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd63)
                    state_next = ST_ROUND;
                else if (pad80_reg && fill_reg == 6'd56)
                    state_next = ST_LEN;
            end
            ST_LEN:   state_next = ST_ROUND;
            ST_ROUND: if (round_reg == 6'd63) state_next = ST_ADD;
            ST_ADD:
            begin
                if (final_reg && fill_reg == 6'd0 && pad80_reg && len_done_reg)
                    state_next = ST_EMIT;
                else if (final_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_stall && emit_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            len_reg      <= '0;
            round_reg    <= '0;
            emit_reg     <= '0;
            final_reg    <= 1'b0;
            pad80_reg    <= 1'b0;
            len_done_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            if (put_en)
                fill_reg <= fill_reg + 6'd1;
            if (state_reg == ST_IDLE && q_valid)
            begin
                if (q_item.has_data)
                    len_reg <= len_reg + 64'd8;
                final_reg <= q_item.last_byte;
            end
            if (state_reg == ST_PAD)
                pad80_reg <= 1'b1;
            if (state_reg == ST_LEN)
            begin
                fill_reg     <= '0;
                len_done_reg <= 1'b1;
            end
            if (state_reg == ST_ROUND)
                round_reg <= round_reg + 6'd1;
            if (state_reg == ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
            end
            if (state_reg == ST_EMIT && !out_stall)
            begin
                emit_reg <= emit_reg + 3'd1;
                if (emit_reg == 3'd7)
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= init_hash(3'(i));
                    len_reg      <= '0;
                    final_reg    <= 1'b0;
                    pad80_reg    <= 1'b0;
                    len_done_reg <= 1'b0;
                end
            end
        end
    end

    // Block words and working variables
    always_ff @(posedge clk)
    begin
        if (put_en)
            w_reg[widx] <= byte_word;
        if (state_reg == ST_LEN)
        begin
            w_reg[14] <= len_reg[63:32];
            w_reg[15] <= len_reg[31:0];
        end
        if (state_next == ST_ROUND && state_reg != ST_ROUND)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= hash_reg[i];
        end
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign out_valid   = (state_reg == ST_EMIT);
    assign digest_word = hash_reg[emit_reg];
    assign word_index  = emit_reg;
    assign last_word   = (emit_reg == 3'd7);
endmodule

@@ rtl/core/sha256_message_hasher.sv @@
// SHA-256 hasher top level: front-end queue feeding the compression back end.
// Depends on sha256_pkg, sha256_front, sha256_back.
//
// Feed one message byte per item (has_data=1); set last_byte on the final
// item, or send has_data=0 with last_byte=1 to end a message (an empty one
// included). Bytes are absorbed at one per cycle into the block while the
// back end is idle, and none while a full 64-byte block goes through the
// single-round compression unit. At the end the block is padded one byte
// per cycle, compressed (twice if the length does not fit), and the eight
// digest words are emitted in order, word 0 first. A four-entry queue lets
// input keep arriving while a block compresses; idle items are dropped.
module sha256_message_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        has_data,
    input  logic        last_byte,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        out_valid,
    input  logic        out_stall
);
    import sha256_pkg::*;

    sha_item_t q_item;
    logic      q_valid;
    logic      q_pop;

    sha256_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .data_byte(data_byte), .has_data(has_data), .last_byte(last_byte),
        .valid(in_valid), .stall(in_stall),
        .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
    );

    sha256_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
        .out_valid(out_valid), .out_stall(out_stall)
    );
endmodule
